// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL; they expand to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);
// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/trib_pkg.sv -----
// Constants, types and helper functions for the tribonacci matrix power block.
`timescale 1ns / 1ps

package trib_pkg;

    localparam int INDEX_WIDTH = 63;
    localparam int S_TDATA_W   = ((INDEX_WIDTH + 7) / 8) * 8;
    localparam int TERM_W      = 30;
    localparam int M_TDATA_W   = ((TERM_W + 7) / 8) * 8;
    localparam int POS_W       = $clog2(INDEX_WIDTH);

    localparam int MAT_ENTRIES = 9;
    localparam int MEM_DEPTH   = 2 * MAT_ENTRIES;
    localparam int IDX_W       = 4;
    localparam int ADDR_W      = 5;

    localparam logic [TERM_W-1:0] PRIME     = 30'd1000000009;
    localparam logic [31:0]       TWO_PRIME = 32'd2000000018;
    // Barrett constant floor(2^60 / p)
    localparam logic [30:0] BARRETT_MU = 31'(64'h1000_0000_0000_0000 / 64'd1000000009);

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [IDX_W-1:0] dest;
    } tag_t;

    // Entry of the companion matrix [[1,1,1],[1,0,0],[0,1,0]], row-major
    function automatic logic [TERM_W-1:0] comp_entry(input logic [IDX_W-1:0] idx);
        logic [TERM_W-1:0] v;
        case (idx)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd7: v = TERM_W'(1);
            default:                       v = '0;
        endcase
        return v;
    endfunction

    // Bring a value below three times the prime into range
    function automatic logic [TERM_W-1:0] fold3(input logic [31:0] r);
        logic [31:0] v;
        if (r >= TWO_PRIME) begin
            v = r - TWO_PRIME;
        end else if (r >= 32'(PRIME)) begin
            v = r - 32'(PRIME);
        end else begin
            v = r;
        end
        return v[TERM_W-1:0];
    endfunction

endpackage

// ----- hdl/tribonacci_matrix_power_mod.sv -----
// Top level: tribonacci term modulo 1000000009 by 3x3 matrix square-and-multiply.
//
// Input stream (s_): one item per term index n in s_tdata. Index 0 is dropped
// without a result; indices 1..3 answer 0, 1, 2 with no matrix work.
// Output stream (m_): one item per nonzero index, the term in m_tdata.
// For n >= 4 the exponent n-3 is scanned for its top bit, the companion matrix is
// loaded into the matrix memory, and each lower exponent bit costs a step, a
// matrix square and, for a set bit, a further matrix product by the companion.
// Every matrix product streams its 27 scalar products through one pipelined
// modular multiplier (multiply, Barrett quotient, quotient times prime,
// correction).
// s_tready is high only while the block is idle; one item is worked at a time.
// A finished result sits in the output register until taken; the block accepts
// the next item meanwhile, but holds its own result until the register frees.
// Reset (aresetn low, synchronous) returns the block to idle and drops any
// pending result; no state carries between items.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tribonacci_matrix_power_mod (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: [62:0] index_n, zero fill above
    input  logic [trib_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: [29:0] term_value, zero fill above
    output logic [trib_pkg::M_TDATA_W-1:0] m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOAD,
        ST_STEP,
        ST_MUL,
        ST_FIN_RD,
        ST_FIN_CALC,
        ST_OUT
    } state_t;

    localparam int IW = trib_pkg::INDEX_WIDTH;
    localparam int TW = trib_pkg::TERM_W;

    state_t                         state_reg;
    logic [IW-1:0]                  e_reg;
    logic [trib_pkg::POS_W-1:0]     pos_reg;
    logic                           bank_reg;
    logic [trib_pkg::IDX_W-1:0]     load_cnt_reg;
    logic                           mult_mode_reg;
    logic                           issuing_reg;
    logic [1:0]                     i_reg;
    logic [1:0]                     j_reg;
    logic [1:0]                     k_reg;
    logic [TW-1:0]                  value_reg;
    logic                           m_tvalid_reg;
    logic [TW-1:0]                  m_tdata_reg;

    logic [TW-1:0]                  mem [0:trib_pkg::MEM_DEPTH-1];
    logic [TW-1:0]                  rd_a_reg;
    logic [TW-1:0]                  rd_b_reg;
    logic [TW-1:0]                  cb_reg;

    trib_pkg::tag_t                 tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg;
    trib_pkg::tag_t                 issue_tag;
    logic [59:0]                    prod_reg;
    logic [61:0]                    bq_reg;
    logic [31:0]                    xlo2_reg;
    logic [31:0]                    xlo3_reg;
    logic [31:0]                    qp_reg;
    logic [60:0]                    qp_full;
    logic [TW-1:0]                  r_reg;
    logic [TW-1:0]                  acc_reg;
    logic [TW:0]                    acc_sum;
    logic [TW-1:0]                  acc_next;
    logic [TW-1:0]                  b_op;

    logic [IW-1:0]                  n_in;
    logic                           in_fire;
    logic                           mul_done;
    logic [trib_pkg::ADDR_W-1:0]    base_cur;
    logic [trib_pkg::ADDR_W-1:0]    base_oth;
    logic [trib_pkg::IDX_W-1:0]     idx_ik;
    logic [trib_pkg::IDX_W-1:0]     idx_kj;
    logic [trib_pkg::IDX_W-1:0]     idx_ij;
    logic [trib_pkg::ADDR_W-1:0]    addr_a;
    logic [trib_pkg::ADDR_W-1:0]    addr_b;
    logic                           wr_en;
    logic [trib_pkg::ADDR_W-1:0]    wr_addr;
    logic [TW-1:0]                  wr_data;

    assign n_in     = s_tdata[IW-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = trib_pkg::M_TDATA_W'(m_tdata_reg);

    assign base_cur = bank_reg ? trib_pkg::ADDR_W'(trib_pkg::MAT_ENTRIES) : '0;
    assign base_oth = bank_reg ? '0 : trib_pkg::ADDR_W'(trib_pkg::MAT_ENTRIES);
    assign idx_ik   = trib_pkg::IDX_W'(i_reg) * 4'd3 + trib_pkg::IDX_W'(k_reg);
    assign idx_kj   = trib_pkg::IDX_W'(k_reg) * 4'd3 + trib_pkg::IDX_W'(j_reg);
    assign idx_ij   = trib_pkg::IDX_W'(i_reg) * 4'd3 + trib_pkg::IDX_W'(j_reg);

    always_comb begin
        if (state_reg == ST_FIN_RD) begin
            addr_a = base_cur;
            addr_b = base_cur + trib_pkg::ADDR_W'(1);
        end else begin
            addr_a = base_cur + trib_pkg::ADDR_W'(idx_ik);
            addr_b = base_cur + trib_pkg::ADDR_W'(idx_kj);
        end
    end

    assign issue_tag.valid = issuing_reg && (state_reg == ST_MUL);
    assign issue_tag.first = (k_reg == 2'd0);
    assign issue_tag.last  = (k_reg == 2'd2);
    assign issue_tag.dest  = idx_ij;

    // Accumulate the three reduced products of one output entry
    assign acc_sum  = (tag5_reg.first ? '0 : (TW+1)'(acc_reg)) + (TW+1)'(r_reg);
    assign acc_next = (acc_sum >= (TW+1)'(trib_pkg::PRIME))
                      ? TW'(acc_sum - (TW+1)'(trib_pkg::PRIME)) : acc_sum[TW-1:0];
    assign mul_done = tag5_reg.valid && tag5_reg.last
                      && (tag5_reg.dest == trib_pkg::IDX_W'(trib_pkg::MAT_ENTRIES - 1));

    always_comb begin
        if (state_reg == ST_LOAD) begin
            wr_en   = 1'b1;
            wr_addr = base_cur + trib_pkg::ADDR_W'(load_cnt_reg);
            wr_data = trib_pkg::comp_entry(load_cnt_reg);
        end else begin
            wr_en   = tag5_reg.valid && tag5_reg.last;
            wr_addr = base_oth + trib_pkg::ADDR_W'(tag5_reg.dest);
            wr_data = acc_next;
        end
    end

    // Matrix memory: two banks, one written while the other is read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    assign b_op    = mult_mode_reg ? cb_reg : rd_b_reg;
    assign qp_full = 61'(bq_reg[61:31]) * 61'(trib_pkg::PRIME);

    // Pipelined modular multiplier with Barrett reduction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
            tag5_reg <= '0;
        end else begin
            tag1_reg <= issue_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
            tag5_reg <= tag4_reg;
        end
        cb_reg   <= trib_pkg::comp_entry(idx_kj);
        prod_reg <= 60'(rd_a_reg) * 60'(b_op);
        bq_reg   <= 62'(prod_reg[59:29]) * 62'(trib_pkg::BARRETT_MU);
        xlo2_reg <= prod_reg[31:0];
        qp_reg   <= qp_full[31:0];
        xlo3_reg <= xlo2_reg;
        r_reg    <= trib_pkg::fold3(xlo3_reg - qp_reg);
        if (tag5_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            e_reg         <= '0;
            pos_reg       <= '0;
            bank_reg      <= 1'b0;
            load_cnt_reg  <= '0;
            mult_mode_reg <= 1'b0;
            issuing_reg   <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            value_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
        end else begin
            // the output state loads the register itself
            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_fire && (n_in != '0)) begin
                        if ((n_in >> 2) == '0) begin
                            value_reg <= TW'(n_in[1:0] - 2'd1);
                            state_reg <= ST_OUT;
                        end else begin
                            e_reg     <= n_in - IW'(3);
                            pos_reg   <= trib_pkg::POS_W'(IW - 1);
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    // find the leading one of the exponent
                    if (e_reg[IW-1] || (pos_reg == '0)) begin
                        load_cnt_reg <= '0;
                        state_reg    <= ST_LOAD;
                    end else begin
                        e_reg   <= e_reg << 1;
                        pos_reg <= pos_reg - trib_pkg::POS_W'(1);
                    end
                end
                ST_LOAD: begin
                    if (load_cnt_reg == trib_pkg::IDX_W'(trib_pkg::MAT_ENTRIES - 1)) begin
                        state_reg <= ST_STEP;
                    end else begin
                        load_cnt_reg <= load_cnt_reg + trib_pkg::IDX_W'(1);
                    end
                end
                ST_STEP: begin
                    if (pos_reg == '0) begin
                        state_reg <= ST_FIN_RD;
                    end else begin
                        e_reg         <= e_reg << 1;
                        pos_reg       <= pos_reg - trib_pkg::POS_W'(1);
                        mult_mode_reg <= 1'b0;
                        i_reg         <= '0;
                        j_reg         <= '0;
                        k_reg         <= '0;
                        issuing_reg   <= 1'b1;
                        state_reg     <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (issuing_reg) begin
                        if (k_reg == 2'd2) begin
                            k_reg <= '0;
                            if (j_reg == 2'd2) begin
                                j_reg <= '0;
                                if (i_reg == 2'd2) begin
                                    issuing_reg <= 1'b0;
                                end else begin
                                    i_reg <= i_reg + 2'd1;
                                end
                            end else begin
                                j_reg <= j_reg + 2'd1;
                            end
                        end else begin
                            k_reg <= k_reg + 2'd1;
                        end
                    end
                    if (mul_done) begin
                        bank_reg <= ~bank_reg;
                        // after the square, multiply by the companion on a set bit
                        if (!mult_mode_reg && e_reg[IW-1]) begin
                            mult_mode_reg <= 1'b1;
                            i_reg         <= '0;
                            j_reg         <= '0;
                            k_reg         <= '0;
                            issuing_reg   <= 1'b1;
                        end else begin
                            state_reg <= ST_STEP;
                        end
                    end
                end
                ST_FIN_RD: begin
                    state_reg <= ST_FIN_CALC;
                end
                ST_FIN_CALC: begin
                    value_reg <= trib_pkg::fold3({1'b0, rd_a_reg, 1'b0} + 32'(rd_b_reg));
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= value_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `ASSERT_IMPLIES(a_busy_not_ready, tag1_reg.valid || tag5_reg.valid, !s_tready,
        "input accepted while products in flight")
    `ASSERT_IMPLIES(a_done_in_mul, mul_done, state_reg == ST_MUL,
        "matrix product finished outside multiply state")
    `ASSERT_IMPLIES(a_write_reduced, wr_en, wr_data < trib_pkg::PRIME,
        "unreduced value written to matrix memory")
    `ASSERT_IMPLIES(a_prod_reduced, tag5_reg.valid, r_reg < trib_pkg::PRIME,
        "modular product out of range")

endmodule

// ----- test/tb_tribonacci_matrix_power_mod.sv -----
// Self-checking testbench for the tribonacci matrix power block: stream stimulus and term scoreboard.
`timescale 1ns / 1ps

module tb_tribonacci_matrix_power_mod;

    localparam int          INDEX_WIDTH = trib_pkg::INDEX_WIDTH;
    localparam int          S_TDATA_W   = trib_pkg::S_TDATA_W;
    localparam int          TERM_W      = trib_pkg::TERM_W;
    localparam int          M_TDATA_W   = trib_pkg::M_TDATA_W;

    localparam int          CLK_HALF    = 6;
    localparam int          STALL_LIMIT = 20000;
    localparam int          TAIL_CYCLES = 200;
    localparam int          PHASE_TERMS = 50;
    localparam bit [63:0]   MODULUS     = 64'd1000000009;

    // 3x3 matrix, row-major, entry (i,j) at [3*i+j]
    typedef bit [8:0][63:0] mat3_t;

    class term_scoreboard;
        bit [TERM_W-1:0] awaited_terms[$];
        int unsigned     errors;
        int unsigned     checked;

        function mat3_t companion_matrix();
            mat3_t c;
            c = '0;
            c[0] = 1; c[1] = 1; c[2] = 1;
            c[3] = 1;
            c[7] = 1;
            return c;
        endfunction

        function mat3_t mat_mul(mat3_t x, mat3_t y);
            mat3_t     r;
            bit [63:0] acc;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    acc = 0;
                    for (int k = 0; k < 3; k++) begin
                        acc += (x[3*i+k] * y[3*k+j]) % MODULUS;
                    end
                    r[3*i+j] = acc % MODULUS;
                end
            end
            return r;
        endfunction

        // companion^e for e >= 1, scanning from the top set bit down
        function mat3_t mat_pow(bit [63:0] e);
            mat3_t comp;
            mat3_t acc;
            int    top;
            comp = companion_matrix();
            acc  = comp;
            top  = 63;
            while (top > 0 && !e[top]) top--;
            for (int b = top - 1; b >= 0; b--) begin
                acc = mat_mul(acc, acc);
                if (e[b]) acc = mat_mul(acc, comp);
            end
            return acc;
        endfunction

        function bit [TERM_W-1:0] term_of(bit [63:0] n);
            mat3_t     p;
            bit [63:0] v;
            case (n)
                64'd1:   v = 0;
                64'd2:   v = 1;
                64'd3:   v = 2;
                default: begin
                    p = mat_pow(n - 64'd3);
                    v = (p[0] * 64'd2 + p[1]) % MODULUS;
                end
            endcase
            return v[TERM_W-1:0];
        endfunction

        // index zero has no term, so nothing is awaited for it
        function void note_index(bit [S_TDATA_W-1:0] tdata);
            bit [63:0] n;
            n = 64'(tdata[INDEX_WIDTH-1:0]);
            if (n != 0) awaited_terms.push_back(term_of(n));
        endfunction

        function void check_term(bit [M_TDATA_W-1:0] tdata);
            bit [TERM_W-1:0] want;
            bit [TERM_W-1:0] got;
            got = tdata[TERM_W-1:0];
            if (awaited_terms.size() == 0) begin
                $error("term_value with no item outstanding: expected none, actual %0d", got);
                errors++;
                return;
            end
            want = awaited_terms.pop_front();
            checked++;
            if (got !== want) begin
                $error("term_value mismatch: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return awaited_terms.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    term_scoreboard sb;
    int unsigned    src_idle_pct;
    int unsigned    snk_idle_pct;
    int unsigned    stall_cycles;
    int unsigned    zero_items;
    int unsigned    wide_items;

    tribonacci_matrix_power_mod u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Result side: random back-pressure and checking of every accepted item
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
        if (aresetn && m_tvalid && m_tready) sb.check_term(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("tb_tribonacci_matrix_power_mod: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_index(input bit [INDEX_WIDTH-1:0] n);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(n);
        do @(posedge aclk); while (!s_tready);
        sb.note_index(S_TDATA_W'(n));
        if (n == 0) zero_items++;
        if (n[INDEX_WIDTH-1:32] != 0) wide_items++;
    endtask

    // Hold the input side until every awaited term has arrived
    task automatic drain_terms();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Mostly short indices; a few wide ones keep the run length in check
    function automatic bit [INDEX_WIDTH-1:0] random_index();
        bit [63:0] raw;
        int        len;
        int        r;
        raw = {$urandom, $urandom};
        r   = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 15) return INDEX_WIDTH'($urandom_range(8, 1));
        if (r < 82) len = $urandom_range(16, 2);
        else        len = $urandom_range(INDEX_WIDTH, 17);
        raw = raw & ((64'd1 << len) - 1);
        raw[len-1] = 1'b1;
        return raw[INDEX_WIDTH-1:0];
    endfunction

    task automatic random_phase(input int unsigned src_pct, input int unsigned snk_pct);
        bit [INDEX_WIDTH-1:0] n;
        int                   sent;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        sent = 0;
        while (sent < PHASE_TERMS) begin
            n = random_index();
            send_index(n);
            if (n != 0) sent++;
        end
        drain_terms();
    endtask

    initial begin
        bit [INDEX_WIDTH-1:0] directed[$];
        sb           = new();
        src_idle_pct = 37;
        snk_idle_pct = 73;
        zero_items   = 0;
        wide_items   = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // First terms, the dropped index zero, powers of two and the widest indices
        directed = '{63'd1, 63'd2, 63'd3, 63'd4, 63'd5, 63'd6, 63'd7, 63'd0, 63'd8, 63'd11,
                     63'd1000000012, 63'h0000_0001_0000_0003, 63'h4000_0000_0000_0000,
                     63'h4000_0000_0000_0003, 63'h7FFF_FFFF_FFFF_FFFF,
                     63'h7FFF_FFFF_FFFF_FFFE, 63'h5555_5555_5555_5555,
                     63'h2AAA_AAAA_AAAA_AAAA, 63'd0, 63'd1};
        foreach (directed[i]) send_index(directed[i]);
        drain_terms();

        random_phase(37, 73);
        random_phase(73, 37);
        random_phase(0, 0);

        if (sb.pending() != 0) begin
            $error("term_value left outstanding: expected %0d more, actual 0", sb.pending());
            sb.errors++;
        end
        $display("run covered %0d checked terms, %0d zero indices and %0d indices wider than 32 bits",
                 sb.checked, zero_items, wide_items);
        $display("under three sender/receiver stall mixes, with full drains between phases");
        if (sb.errors == 0) begin
            $display("tb_tribonacci_matrix_power_mod: clean");
        end else begin
            $display("tb_tribonacci_matrix_power_mod: errors");
        end
        $finish;
    end

endmodule
